[src/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ADDR_W = 11;
    localparam int IDX_W  = 11;
    localparam int DATA_W = 16;
    localparam int ATTR_W = 8;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register select is paddr[2]
    localparam logic REG_ATTR = 1'b0;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0720;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the request fields
        logic put_char;    // write cell at cursor (unless newline) and move cursor
        logic cnt_clear;
        logic cnt_inc;
        logic fill_wr;     // write fill value at sweep counter
        logic fill_blank;  // fill value is the blank cell, else space in attribute
        logic copy_rd;     // scroll: read cell cnt+COLUMNS, write it to cnt next cycle
        logic read_rd;     // read request cell
        logic load_result;
    } tcw_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             scroll;
        logic             cnt_end;
        logic             copy_end;
        logic             out_free;
    } tcw_stat_t;

endpackage

`default_nettype wire

[src/tcw_intf.sv]
`default_nettype none

interface tcw_req_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::CMD_W-1:0]   cmd;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::ADDR_W-1:0]  cell_address;

    modport source (output valid, cmd, char_code, cell_address, input ready);
    modport sink   (input valid, cmd, char_code, cell_address, output ready);
endinterface

interface tcw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::IDX_W-1:0]   cursor_index;
    logic [tcw_pkg::DATA_W-1:0]  cell_data;

    modport source (output valid, cursor_index, cell_data, input ready);
    modport sink   (input valid, cursor_index, cell_data, output ready);
endinterface

`default_nettype wire

[src/text_console_writer_unit.sv]
// Text console store: a COLUMNS x ROWS grid of 16-bit cells (attribute high
// byte, character low byte) with a cursor.
// Requests come in on req_chan (cmd, char_code, cell_address); every request
// gives exactly one response on rsp_chan (cursor_index, cell_data), in order.
// cmd: put character, clear screen, read cell. The attribute byte used by put
// and clear is written over the APB port at address 0 (reset value 7).
// The cell store is a single-write, single-read memory, so whole-screen
// work takes one cell per cycle: clear rewrites every cell, and a put that
// scrolls copies rows up, then blanks the bottom row.
// Reset: cursor goes to 0 and a clearing pass fills the store with 0x0720;
// req_chan.ready stays low until it ends.
// The response sits in an output register; a stalled receiver does not stop
// the next request from being taken, but its response waits until the
// register frees up.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    tcw_req_if.sink                           req_chan,
    tcw_rsp_if.source                         rsp_chan,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int CELLS = COLUMNS * ROWS;

    tcw_pkg::tcw_ctrl_t          ctrl;
    tcw_pkg::tcw_stat_t          stat;
    logic [tcw_pkg::ATTR_W-1:0]  attr;

    tcw_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .attr    (attr)
    );

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_chan.valid),
        .req_ready (req_chan.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .stat             (stat),
        .req_cmd          (req_chan.cmd),
        .req_char_code    (req_chan.char_code),
        .req_cell_address (req_chan.cell_address),
        .attr             (attr),
        .rsp_ready        (rsp_chan.ready),
        .rsp_valid        (rsp_chan.valid),
        .rsp_cursor_index (rsp_chan.cursor_index),
        .rsp_cell_data    (rsp_chan.cell_data)
    );

    // one request at a time: ready drops right after a request is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
        else $error("request taken while previous one still in work");

    // the cursor never points outside the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_chan.valid |-> (32'(rsp_chan.cursor_index) < CELLS
                            || CELLS > (1 << tcw_pkg::IDX_W)))
        else $error("cursor index beyond screen");

    // a response is never loaded on the cycle a request is taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_result |-> !(req_chan.valid && req_chan.ready))
        else $error("response loaded while a request is taken");

endmodule

`default_nettype wire

[src/tcw_apb.sv]
`default_nettype none

module tcw_apb (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic      [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output logic      [tcw_pkg::ATTR_W-1:0]   attr
);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == tcw_pkg::REG_ATTR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tcw_pkg::ATTR_RESET;
        end
        else if (wr_en)
        begin
            attr_reg <= pwdata[tcw_pkg::ATTR_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == tcw_pkg::REG_ATTR)
        begin
            prdata[tcw_pkg::ATTR_W-1:0] = attr_reg;
        end
    end

    assign attr = attr_reg;

endmodule

`default_nettype wire

[src/tcw_ctrl.sv]
`default_nettype none

module tcw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire tcw_pkg::tcw_stat_t  stat,
    output tcw_pkg::tcw_ctrl_t       ctrl
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_PUT,
        S_SCROLL,
        S_TAIL,
        S_FILL,
        S_CLEAR,
        S_READ,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ctrl.fill_wr    = 1'b1;
                ctrl.fill_blank = 1'b1;
                ctrl.cnt_inc    = 1'b1;
                if (stat.cnt_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready    = 1'b1;
                ctrl.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctrl.cnt_clear = 1'b1;
                case (stat.cmd)
                    tcw_pkg::CMD_PUT:   state_next = S_PUT;
                    tcw_pkg::CMD_CLEAR: state_next = S_CLEAR;
                    tcw_pkg::CMD_READ:  state_next = S_READ;
                    default:            state_next = S_FINISH;
                endcase
            end
            S_PUT:
            begin
                ctrl.put_char = 1'b1;
                state_next    = stat.scroll ? S_SCROLL : S_FINISH;
            end
            S_SCROLL:
            begin
                ctrl.copy_rd = 1'b1;
                ctrl.cnt_inc = 1'b1;
                if (stat.copy_end)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                // last copied cell is written this cycle
                state_next = S_FILL;
            end
            S_FILL:
            begin
                ctrl.fill_wr    = 1'b1;
                ctrl.fill_blank = 1'b1;
                ctrl.cnt_inc    = 1'b1;
                if (stat.cnt_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_CLEAR:
            begin
                ctrl.fill_wr = 1'b1;
                ctrl.cnt_inc = 1'b1;
                if (stat.cnt_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                ctrl.read_rd = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.load_result = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[src/tcw_datapath.sv]
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tcw_pkg::tcw_ctrl_t          ctrl,
    output tcw_pkg::tcw_stat_t               stat,
    input  wire logic [tcw_pkg::CMD_W-1:0]   req_cmd,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  req_char_code,
    input  wire logic [tcw_pkg::ADDR_W-1:0]  req_cell_address,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  attr,
    input  wire logic                        rsp_ready,
    output logic                             rsp_valid,
    output logic      [tcw_pkg::IDX_W-1:0]   rsp_cursor_index,
    output logic      [tcw_pkg::DATA_W-1:0]  rsp_cell_data
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CMP_W   = (CELL_AW > tcw_pkg::ADDR_W) ? CELL_AW + 1 : tcw_pkg::ADDR_W + 1;

    logic [tcw_pkg::DATA_W-1:0] mem [CELLS];

    logic [tcw_pkg::CMD_W-1:0]  cmd_reg;
    logic [tcw_pkg::CHAR_W-1:0] char_reg;
    logic [tcw_pkg::ADDR_W-1:0] addr_reg;
    logic [COL_W-1:0]           col_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [CELL_AW-1:0]         cnt_reg;
    logic                       copy_pend_reg;
    logic [CELL_AW-1:0]         copy_addr_reg;
    logic [tcw_pkg::DATA_W-1:0] rd_data_reg;
    logic                       out_valid_reg;
    logic [tcw_pkg::IDX_W-1:0]  out_idx_reg;
    logic [tcw_pkg::DATA_W-1:0] out_data_reg;

    logic [COL_W-1:0]           col_next;
    logic [ROW_W-1:0]           row_next;
    logic                       is_newline;
    logic                       row_adv;
    logic                       row_last;
    logic                       scroll;
    logic [CELL_AW-1:0]         cur_lin;
    logic                       addr_ok;
    logic [CELL_AW-1:0]         addr_cell;
    logic                       wr_en;
    logic [CELL_AW-1:0]         wr_addr;
    logic [tcw_pkg::DATA_W-1:0] wr_data;
    logic                       rd_en;
    logic [CELL_AW-1:0]         rd_addr;

    // cursor step for a put
    assign is_newline = (char_reg == tcw_pkg::NEWLINE_CODE);
    assign row_last   = (row_reg == ROW_W'(ROWS - 1));
    assign row_adv    = is_newline || (col_reg == COL_W'(COLUMNS - 1));
    assign scroll     = row_adv && row_last;
    assign col_next   = row_adv ? '0 : COL_W'(col_reg + 1'b1);
    assign row_next   = (row_adv && !row_last) ? ROW_W'(row_reg + 1'b1) : row_reg;

    assign cur_lin   = CELL_AW'(CELL_AW'(row_reg) * CELL_AW'(COLUMNS)) + CELL_AW'(col_reg);
    assign addr_ok   = (CMP_W'(addr_reg) < CMP_W'(CELLS));
    assign addr_cell = CELL_AW'(addr_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg;
        wr_data = tcw_pkg::BLANK_CELL;
        if (copy_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data_reg;
        end
        else if (ctrl.fill_wr)
        begin
            wr_en   = 1'b1;
            wr_data = ctrl.fill_blank ? tcw_pkg::BLANK_CELL : {attr, tcw_pkg::SPACE_CODE};
        end
        else if (ctrl.put_char && !is_newline)
        begin
            wr_en   = 1'b1;
            wr_addr = cur_lin;
            wr_data = {attr, char_reg};
        end
    end

    assign rd_en   = ctrl.copy_rd || (ctrl.read_rd && addr_ok);
    assign rd_addr = ctrl.copy_rd ? CELL_AW'(cnt_reg + CELL_AW'(COLUMNS)) : addr_cell;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= req_cmd;
            char_reg <= req_char_code;
            addr_reg <= req_cell_address;
        end
        copy_addr_reg <= cnt_reg;
        if (ctrl.load_result)
        begin
            out_idx_reg  <= tcw_pkg::IDX_W'(cur_lin);
            out_data_reg <= (cmd_reg == tcw_pkg::CMD_READ && addr_ok) ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            copy_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.put_char)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (ctrl.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.cnt_inc)
            begin
                cnt_reg <= CELL_AW'(cnt_reg + 1'b1);
            end
            copy_pend_reg <= ctrl.copy_rd;
            if (ctrl.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat          = '0;
        stat.cmd      = cmd_reg;
        stat.scroll   = scroll;
        stat.cnt_end  = (cnt_reg == CELL_AW'(CELLS - 1));
        stat.copy_end = (cnt_reg == CELL_AW'(CELLS - COLUMNS - 1));
        stat.out_free = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_cursor_index = out_idx_reg;
    assign rsp_cell_data    = out_data_reg;

endmodule

`default_nettype wire
